@@ rtl/core/first_fit_heap_allocator_top_macros.svh @@
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffa: implication check failed");
`define FFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffa: next-cycle check failed");
`else
`define FFA_ASSERT_IMPL(label, ante, cons)
`define FFA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/ffa_pkg.sv @@
// Types and constants shared by the heap allocator modules.
package ffa_pkg;

  localparam int PW = 18;
  localparam logic [7:0] USED_MARK = 8'd1;
  localparam logic [7:0] FREE_MARK = 8'd0;
  localparam logic [PW-1:0] HDR_BYTES = PW'(3);

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_INIT2, S_IDLE, S_DISPATCH,
    S_HR0, S_HR1, S_HR2, S_HR3,
    S_A_LOOP, S_A_EVAL, S_AW_MARK, S_AW_SHI, S_AW_SLO, S_AW_RMK, S_AW_RHI, S_AW_RLO,
    S_F_CHECK, S_F_MARK, S_F_WALK, S_F_ADV, S_F_CLR,
    S_M_LOOP, S_M_EVAL, S_M_IN, S_M_IN2, S_M_WHI, S_M_WLO,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {RAM_IDLE, RAM_RD, RAM_WR} ram_op_t;
  typedef enum logic [1:0] {A_POS, A_REST, A_HDR, A_NXT} asel_t;
  typedef enum logic [2:0] {
    W_ZERO, W_ONE, W_SZ_HI, W_SZ_LO, W_REST_HI, W_REST_LO, W_BLK_HI, W_BLK_LO
  } wsel_t;
  typedef enum logic [1:0] {CAP_NONE, CAP_MARK, CAP_HI, CAP_LO} cap_t;
  typedef enum logic [1:0] {POS_HOLD, POS_ZERO, POS_ADV_HSIZE, POS_ADV_BLK} pos_op_t;
  typedef enum logic [1:0] {BLK_HOLD, BLK_LOAD, BLK_ADD} blk_op_t;
  typedef enum logic [1:0] {RES_NONE, RES_FAIL, RES_ALLOC, RES_FREE} res_t;
  typedef enum logic [1:0] {W_INIT_NONE, W_INIT_ZERO, W_INIT_HI, W_INIT_LO} init_t;

  typedef struct packed {
    logic    lat_req;
    ram_op_t ram_op;
    asel_t   asel;
    logic [1:0] off;
    wsel_t   wsel;
    init_t   init;
    cap_t    cap;
    pos_op_t pos_op;
    blk_op_t blk_op;
    res_t    res;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic size_bad;
    logic alloc_room;
    logic fit;
    logic split;
    logic free_bad;
    logic mark_used;
    logic mark_free;
    logic pos_lt_hdr;
    logic pos_eq_hdr;
    logic pos_lt_mem;
    logic end_hit;
    logic nxt_lt_mem;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/ffa_req_if.sv @@
// Request channel: valid/ready with allocate or free fields.
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] request_size;
  logic [15:0] block_address;
  modport source (output valid, operation, request_size, block_address, input ready);
  modport sink (input valid, operation, request_size, block_address, output ready);
endinterface

@@ rtl/core/ffa_rsp_if.sv @@
// Result channel: valid/ready with status and payload address.
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] payload_address;
  modport source (output valid, status, payload_address, input ready);
  modport sink (input valid, status, payload_address, output ready);
endinterface

@@ rtl/core/ffa_ram.sv @@
// Generic single-port RAM with registered read.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/core/ffa_dp.sv @@
// Allocator datapath: header walk registers, heap RAM and result registers.
module ffa_dp #(
  parameter int MEM_SIZE = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ffa_pkg::cmd_t      cmd,
  output ffa_pkg::stat_t     stat,
  input  logic               in_operation,
  input  logic [15:0]        in_request_size,
  input  logic [15:0]        in_block_address,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [15:0]        out_payload_address
);
  localparam int PW = ffa_pkg::PW;
  localparam int AW = $clog2(MEM_SIZE);
  localparam logic [PW-1:0] MEM_PW = PW'(MEM_SIZE);
  localparam logic [15:0] INIT_SIZE = 16'(MEM_SIZE - 3);

  logic          op_r;
  logic [15:0]   size_r, baddr_r;
  logic [PW-1:0] pos_r, pos_nxt, blk_r, blk_nxt;
  logic [7:0]    hmark_r;
  logic [15:0]   hsize_r;
  logic          rd_ok_r;
  logic          res_stat_r;
  logic [15:0]   res_addr_r;
  logic          out_valid_r, out_stat_r;
  logic [15:0]   out_addr_r;

  logic [PW-1:0] hdr, base, addr, pos_hs, pos_blk, rest_sz;
  logic          in_range, we;
  logic [7:0]    wdata, rdata, rbyte;
  logic [15:0]   rem;

  assign hdr     = PW'(baddr_r) - ffa_pkg::HDR_BYTES;
  assign pos_hs  = pos_r + PW'(hsize_r) + ffa_pkg::HDR_BYTES;
  assign pos_blk = pos_r + blk_r + ffa_pkg::HDR_BYTES;
  assign rest_sz = pos_r + PW'(size_r) + ffa_pkg::HDR_BYTES;
  assign rem     = hsize_r - size_r - 16'd3;

  always_comb begin
    case (cmd.asel)
      ffa_pkg::A_POS:  base = pos_r;
      ffa_pkg::A_REST: base = rest_sz;
      ffa_pkg::A_HDR:  base = hdr;
      default:         base = pos_blk;
    endcase
  end

  assign addr     = base + PW'(cmd.off);
  assign in_range = addr < MEM_PW;
  assign we       = (cmd.ram_op == ffa_pkg::RAM_WR) && in_range;

  always_comb begin
    case (cmd.init)
      ffa_pkg::W_INIT_HI: wdata = INIT_SIZE[15:8];
      ffa_pkg::W_INIT_LO: wdata = INIT_SIZE[7:0];
      ffa_pkg::W_INIT_ZERO: wdata = ffa_pkg::FREE_MARK;
      default: begin
        case (cmd.wsel)
          ffa_pkg::W_ONE:     wdata = ffa_pkg::USED_MARK;
          ffa_pkg::W_SZ_HI:   wdata = size_r[15:8];
          ffa_pkg::W_SZ_LO:   wdata = size_r[7:0];
          ffa_pkg::W_REST_HI: wdata = rem[15:8];
          ffa_pkg::W_REST_LO: wdata = rem[7:0];
          ffa_pkg::W_BLK_HI:  wdata = blk_r[15:8];
          ffa_pkg::W_BLK_LO:  wdata = blk_r[7:0];
          default:            wdata = ffa_pkg::FREE_MARK;
        endcase
      end
    endcase
  end

  ffa_ram #(.WIDTH(8), .DEPTH(MEM_SIZE)) u_heap (
    .clk   (clk),
    .we    (we),
    .addr  (addr[AW-1:0]),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign rbyte = rd_ok_r ? rdata : 8'd0;

  always_comb begin
    case (cmd.pos_op)
      ffa_pkg::POS_ZERO:      pos_nxt = '0;
      ffa_pkg::POS_ADV_HSIZE: pos_nxt = pos_hs;
      ffa_pkg::POS_ADV_BLK:   pos_nxt = pos_blk;
      default:                pos_nxt = pos_r;
    endcase
    case (cmd.blk_op)
      ffa_pkg::BLK_LOAD: blk_nxt = PW'(hsize_r);
      ffa_pkg::BLK_ADD:  blk_nxt = blk_r + PW'(hsize_r) + ffa_pkg::HDR_BYTES;
      default:           blk_nxt = blk_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= cmd.lat_req ? '0 : pos_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= (cmd.ram_op == ffa_pkg::RAM_RD) && in_range;
    blk_r   <= blk_nxt;
    if (cmd.lat_req) begin
      op_r    <= in_operation;
      size_r  <= in_request_size;
      baddr_r <= in_block_address;
    end
    case (cmd.cap)
      ffa_pkg::CAP_MARK: hmark_r <= rbyte;
      ffa_pkg::CAP_HI:   hsize_r[15:8] <= rbyte;
      ffa_pkg::CAP_LO:   hsize_r[7:0] <= rbyte;
      default: ;
    endcase
    case (cmd.res)
      ffa_pkg::RES_FAIL: begin
        res_stat_r <= 1'b1;
        res_addr_r <= 16'd0;
      end
      ffa_pkg::RES_ALLOC: begin
        res_stat_r <= 1'b0;
        res_addr_r <= 16'(pos_r + ffa_pkg::HDR_BYTES);
      end
      ffa_pkg::RES_FREE: begin
        res_stat_r <= 1'b0;
        res_addr_r <= 16'd0;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_stat_r <= res_stat_r;
      out_addr_r <= res_addr_r;
    end
  end

  always_comb begin
    stat.op_free    = op_r;
    stat.size_bad   = (size_r == 16'd0) || (PW'(size_r) + ffa_pkg::HDR_BYTES > MEM_PW);
    stat.alloc_room = rest_sz <= MEM_PW;
    stat.fit        = (hmark_r != ffa_pkg::USED_MARK) && (hsize_r >= size_r);
    stat.split      = (hsize_r - size_r) >= 16'd3;
    stat.free_bad   = (PW'(baddr_r) > MEM_PW) || (PW'(baddr_r) < ffa_pkg::HDR_BYTES);
    stat.mark_used  = hmark_r == ffa_pkg::USED_MARK;
    stat.mark_free  = hmark_r == ffa_pkg::FREE_MARK;
    stat.pos_lt_hdr = pos_r < hdr;
    stat.pos_eq_hdr = pos_r == hdr;
    stat.pos_lt_mem = pos_r < MEM_PW;
    stat.end_hit    = pos_hs == MEM_PW;
    stat.nxt_lt_mem = pos_blk < MEM_PW;
    stat.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_stat_r;
  assign out_payload_address = out_addr_r;
endmodule

@@ rtl/core/ffa_ctrl.sv @@
// Allocator controller: sequences header walks, splits, merges and results.
module ffa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffa_pkg::stat_t stat,
  output ffa_pkg::cmd_t  cmd
);
  ffa_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  ffa_pkg::asel_t  hsel_r, hsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::S_INIT0;
      ret_r   <= ffa_pkg::S_IDLE;
      hsel_r  <= ffa_pkg::A_POS;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      hsel_r  <= hsel_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    hsel_nxt  = hsel_r;
    unique case (state_r)
      ffa_pkg::S_INIT0: state_nxt = ffa_pkg::S_INIT1;
      ffa_pkg::S_INIT1: state_nxt = ffa_pkg::S_INIT2;
      ffa_pkg::S_INIT2: state_nxt = ffa_pkg::S_IDLE;
      ffa_pkg::S_IDLE: if (in_valid) state_nxt = ffa_pkg::S_DISPATCH;
      ffa_pkg::S_DISPATCH: begin
        if (stat.op_free) state_nxt = ffa_pkg::S_F_CHECK;
        else if (stat.size_bad) state_nxt = ffa_pkg::S_DONE;
        else state_nxt = ffa_pkg::S_A_LOOP;
      end
      ffa_pkg::S_HR0: state_nxt = ffa_pkg::S_HR1;
      ffa_pkg::S_HR1: state_nxt = ffa_pkg::S_HR2;
      ffa_pkg::S_HR2: state_nxt = ffa_pkg::S_HR3;
      ffa_pkg::S_HR3: state_nxt = ret_r;
      ffa_pkg::S_A_LOOP: begin
        if (stat.alloc_room) begin
          state_nxt = ffa_pkg::S_HR0;
          ret_nxt   = ffa_pkg::S_A_EVAL;
          hsel_nxt  = ffa_pkg::A_POS;
        end else begin
          state_nxt = ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_A_EVAL: state_nxt = stat.fit ? ffa_pkg::S_AW_MARK : ffa_pkg::S_A_LOOP;
      ffa_pkg::S_AW_MARK: state_nxt = stat.split ? ffa_pkg::S_AW_SHI : ffa_pkg::S_DONE;
      ffa_pkg::S_AW_SHI: state_nxt = ffa_pkg::S_AW_SLO;
      ffa_pkg::S_AW_SLO: state_nxt = ffa_pkg::S_AW_RMK;
      ffa_pkg::S_AW_RMK: state_nxt = ffa_pkg::S_AW_RHI;
      ffa_pkg::S_AW_RHI: state_nxt = ffa_pkg::S_AW_RLO;
      ffa_pkg::S_AW_RLO: state_nxt = ffa_pkg::S_DONE;
      ffa_pkg::S_F_CHECK: begin
        if (stat.free_bad) begin
          state_nxt = ffa_pkg::S_DONE;
        end else begin
          state_nxt = ffa_pkg::S_HR0;
          ret_nxt   = ffa_pkg::S_F_MARK;
          hsel_nxt  = ffa_pkg::A_HDR;
        end
      end
      ffa_pkg::S_F_MARK: state_nxt = stat.mark_used ? ffa_pkg::S_F_WALK : ffa_pkg::S_DONE;
      ffa_pkg::S_F_WALK: begin
        if (stat.pos_lt_hdr) begin
          state_nxt = ffa_pkg::S_HR0;
          ret_nxt   = ffa_pkg::S_F_ADV;
          hsel_nxt  = ffa_pkg::A_POS;
        end else if (stat.pos_eq_hdr) begin
          state_nxt = ffa_pkg::S_F_CLR;
        end else begin
          state_nxt = ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_F_ADV: state_nxt = ffa_pkg::S_F_WALK;
      ffa_pkg::S_F_CLR: state_nxt = ffa_pkg::S_M_LOOP;
      ffa_pkg::S_M_LOOP: begin
        if (stat.pos_lt_mem) begin
          state_nxt = ffa_pkg::S_HR0;
          ret_nxt   = ffa_pkg::S_M_EVAL;
          hsel_nxt  = ffa_pkg::A_POS;
        end else begin
          state_nxt = ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_M_EVAL: begin
        if (stat.end_hit) state_nxt = ffa_pkg::S_DONE;
        else if (stat.mark_free) state_nxt = ffa_pkg::S_M_IN;
        else state_nxt = ffa_pkg::S_M_LOOP;
      end
      ffa_pkg::S_M_IN: begin
        if (stat.nxt_lt_mem) begin
          state_nxt = ffa_pkg::S_HR0;
          ret_nxt   = ffa_pkg::S_M_IN2;
          hsel_nxt  = ffa_pkg::A_NXT;
        end else begin
          state_nxt = ffa_pkg::S_M_WHI;
        end
      end
      ffa_pkg::S_M_IN2: state_nxt = stat.mark_free ? ffa_pkg::S_M_IN : ffa_pkg::S_M_WHI;
      ffa_pkg::S_M_WHI: state_nxt = ffa_pkg::S_M_WLO;
      ffa_pkg::S_M_WLO: state_nxt = ffa_pkg::S_M_LOOP;
      ffa_pkg::S_DONE: if (stat.out_free) state_nxt = ffa_pkg::S_IDLE;
      default: state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.ram_op   = ffa_pkg::RAM_IDLE;
    cmd.asel     = ffa_pkg::A_POS;
    cmd.wsel     = ffa_pkg::W_ZERO;
    cmd.init     = ffa_pkg::W_INIT_NONE;
    cmd.cap      = ffa_pkg::CAP_NONE;
    cmd.pos_op   = ffa_pkg::POS_HOLD;
    cmd.blk_op   = ffa_pkg::BLK_HOLD;
    cmd.res      = ffa_pkg::RES_NONE;
    in_ready     = 1'b0;
    unique case (state_r)
      ffa_pkg::S_INIT0: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.init   = ffa_pkg::W_INIT_ZERO;
      end
      ffa_pkg::S_INIT1: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.off    = 2'd1;
        cmd.init   = ffa_pkg::W_INIT_HI;
      end
      ffa_pkg::S_INIT2: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.off    = 2'd2;
        cmd.init   = ffa_pkg::W_INIT_LO;
      end
      ffa_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.lat_req = in_valid;
      end
      ffa_pkg::S_DISPATCH: begin
        if (!stat.op_free && stat.size_bad) cmd.res = ffa_pkg::RES_FAIL;
      end
      ffa_pkg::S_HR0: begin
        cmd.ram_op = ffa_pkg::RAM_RD;
        cmd.asel   = hsel_r;
      end
      ffa_pkg::S_HR1: begin
        cmd.ram_op = ffa_pkg::RAM_RD;
        cmd.asel   = hsel_r;
        cmd.off    = 2'd1;
        cmd.cap    = ffa_pkg::CAP_MARK;
      end
      ffa_pkg::S_HR2: begin
        cmd.ram_op = ffa_pkg::RAM_RD;
        cmd.asel   = hsel_r;
        cmd.off    = 2'd2;
        cmd.cap    = ffa_pkg::CAP_HI;
      end
      ffa_pkg::S_HR3: cmd.cap = ffa_pkg::CAP_LO;
      ffa_pkg::S_A_LOOP: if (!stat.alloc_room) cmd.res = ffa_pkg::RES_FAIL;
      ffa_pkg::S_A_EVAL: if (!stat.fit) cmd.pos_op = ffa_pkg::POS_ADV_HSIZE;
      ffa_pkg::S_AW_MARK: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.wsel   = ffa_pkg::W_ONE;
        if (!stat.split) cmd.res = ffa_pkg::RES_ALLOC;
      end
      ffa_pkg::S_AW_SHI: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.off    = 2'd1;
        cmd.wsel   = ffa_pkg::W_SZ_HI;
      end
      ffa_pkg::S_AW_SLO: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.off    = 2'd2;
        cmd.wsel   = ffa_pkg::W_SZ_LO;
      end
      ffa_pkg::S_AW_RMK: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.asel   = ffa_pkg::A_REST;
        cmd.wsel   = ffa_pkg::W_ZERO;
      end
      ffa_pkg::S_AW_RHI: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.asel   = ffa_pkg::A_REST;
        cmd.off    = 2'd1;
        cmd.wsel   = ffa_pkg::W_REST_HI;
      end
      ffa_pkg::S_AW_RLO: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.asel   = ffa_pkg::A_REST;
        cmd.off    = 2'd2;
        cmd.wsel   = ffa_pkg::W_REST_LO;
        cmd.res    = ffa_pkg::RES_ALLOC;
      end
      ffa_pkg::S_F_CHECK: if (stat.free_bad) cmd.res = ffa_pkg::RES_FAIL;
      ffa_pkg::S_F_MARK: if (!stat.mark_used) cmd.res = ffa_pkg::RES_FAIL;
      ffa_pkg::S_F_WALK: begin
        if (!stat.pos_lt_hdr && !stat.pos_eq_hdr) cmd.res = ffa_pkg::RES_FAIL;
      end
      ffa_pkg::S_F_ADV: cmd.pos_op = ffa_pkg::POS_ADV_HSIZE;
      ffa_pkg::S_F_CLR: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.asel   = ffa_pkg::A_HDR;
        cmd.wsel   = ffa_pkg::W_ZERO;
        cmd.pos_op = ffa_pkg::POS_ZERO;
      end
      ffa_pkg::S_M_LOOP: if (!stat.pos_lt_mem) cmd.res = ffa_pkg::RES_FREE;
      ffa_pkg::S_M_EVAL: begin
        if (stat.end_hit) cmd.res = ffa_pkg::RES_FREE;
        else if (stat.mark_free) cmd.blk_op = ffa_pkg::BLK_LOAD;
        else cmd.pos_op = ffa_pkg::POS_ADV_HSIZE;
      end
      ffa_pkg::S_M_IN: ;
      ffa_pkg::S_M_IN2: if (stat.mark_free) cmd.blk_op = ffa_pkg::BLK_ADD;
      ffa_pkg::S_M_WHI: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.off    = 2'd1;
        cmd.wsel   = ffa_pkg::W_BLK_HI;
      end
      ffa_pkg::S_M_WLO: begin
        cmd.ram_op = ffa_pkg::RAM_WR;
        cmd.off    = 2'd2;
        cmd.wsel   = ffa_pkg::W_BLK_LO;
        cmd.pos_op = ffa_pkg::POS_ADV_BLK;
      end
      ffa_pkg::S_DONE: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end
endmodule

@@ rtl/core/first_fit_heap_allocator_top.sv @@
// channel   dir  handshake              payload
// in_req    in   valid/ready (request)  operation, request_size, block_address
// out_rsp   out  valid/ready            status, payload_address
// One request at a time; each header read runs HR0 to HR3 on the single RAM port.
// Allocate: walk headers to the first free block that fits, mark it used and, on a split,
// write its size and a free header for the rest; a bad size fails at once.
// Free: check the header, walk to it from the start, clear its mark and merge free runs.
// After reset INIT0 to INIT2 write the first header; no request is taken until then.
// A request's final cycle waits while the previous result is still pending and not taken;
// a new request is taken while the previous result is still pending.
`include "first_fit_heap_allocator_top_macros.svh"
module first_fit_heap_allocator_top #(
  parameter int MEM_SIZE = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  ffa_req_if.sink   in_req,
  ffa_rsp_if.source out_rsp
);
  ffa_pkg::cmd_t  cmd;
  ffa_pkg::stat_t stat;
  logic           in_ready;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffa_dp #(.MEM_SIZE(MEM_SIZE)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_operation        (in_req.operation),
    .in_request_size     (in_req.request_size),
    .in_block_address    (in_req.block_address),
    .out_valid           (out_rsp.valid),
    .out_ready           (out_rsp.ready),
    .out_status          (out_rsp.status),
    .out_payload_address (out_rsp.payload_address)
  );

  assign in_req.ready = in_ready;

  `FFA_ASSERT_NEXT(a_one_request, in_req.valid && in_req.ready, !in_req.ready)
  `FFA_ASSERT_IMPL(a_addr_ok, out_rsp.valid && out_rsp.payload_address != 16'd0, out_rsp.status == 1'b0)
  `FFA_ASSERT_IMPL(a_load_free, cmd.out_load, !out_rsp.valid || out_rsp.ready)
endmodule
